// ===== src/serial_frame_collector_top_macros.svh =====
// Assertion macros for the serial frame collector checker.
// Plain text macros only; the checker supplies aclk and aresetn.
`ifndef SERIAL_FRAME_COLLECTOR_TOP_MACROS_SVH
`define SERIAL_FRAME_COLLECTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serial frame collector: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serial frame collector: next-cycle check failed");

`endif

// ===== src/sfc_pkg.sv =====
// Shared constants and types for the serial frame collector.
// No dependencies; imported by the store, collection, emission and top-level modules.
package sfc_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int CMP_W       = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
    localparam int MIN_HELD    = 8;

    localparam logic [BYTE_W-1:0] CR_BYTE      = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE      = 8'h0A;
    localparam logic [BYTE_W-1:0] VERSION_RST  = 8'h01;

    typedef enum logic {
        EM_IDLE,
        EM_READ
    } emit_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } emit_req_t;

endpackage

// ===== src/sfc_frame_ram.sv =====
// Frame store: one write port, one registered read port.
// Depends on sfc_pkg for depth and widths.
module sfc_frame_ram (
    input  logic                         aclk,
    input  sfc_pkg::ram_wr_t             wr,
    input  logic                         rd_en,
    input  logic [sfc_pkg::ADDR_W-1:0]   rd_addr,
    output logic [sfc_pkg::BYTE_W-1:0]   rd_data
);
    import sfc_pkg::*;

    logic [BYTE_W-1:0] mem [FRAME_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sfc_collect.sv =====
// Collection side: fill count, header copies and the frame check per item.
// Depends on sfc_pkg; drives the frame store write port and the emit request.
module sfc_collect (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [sfc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        cfg_wr_en,
    input  logic [sfc_pkg::BYTE_W-1:0]  cfg_wr_data,
    output sfc_pkg::ram_wr_t            wr,
    output sfc_pkg::emit_req_t          req
);
    import sfc_pkg::*;

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] byte0_reg, len_reg, prev_reg, ver_reg;
    logic              acc;
    logic [CNT_W-1:0]  fill_new;
    logic [BYTE_W-1:0] len_eff;
    logic              frame_ok, drop;

    always_comb begin
        acc      = s_tvalid && s_tready;
        fill_new = fill_reg + CNT_W'(1);
        // length byte is the current item when it lands in slot 1
        len_eff  = (fill_reg == CNT_W'(1)) ? rx_byte : len_reg;
        frame_ok = (fill_reg != '0)
                && (CMP_W'(len_eff) == CMP_W'(fill_new))
                && (prev_reg == CR_BYTE)
                && (rx_byte == LF_BYTE)
                && (byte0_reg == ver_reg);
        drop     = (fill_new > CNT_W'(MIN_HELD))
                && ((CMP_W'(fill_new) >= CMP_W'(len_eff))
                    || (fill_new == CNT_W'(FRAME_BYTES)));
        fill_next = fill_reg;
        if (acc) begin
            fill_next = (frame_ok || drop) ? '0 : fill_new;
        end
        wr.we     = acc;
        wr.addr   = fill_reg[ADDR_W-1:0];
        wr.data   = rx_byte;
        req.start = acc && frame_ok;
        req.len   = fill_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ver_reg  <= VERSION_RST;
        end else begin
            fill_reg <= fill_next;
            if (cfg_wr_en) begin
                ver_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            prev_reg <= rx_byte;
            if (fill_reg == '0) begin
                byte0_reg <= rx_byte;
            end
            if (fill_reg == CNT_W'(1)) begin
                len_reg <= rx_byte;
            end
        end
    end

endmodule

// ===== src/sfc_emit.sv =====
// Emission side: reads a completed frame out of the store into the output register.
// Depends on sfc_pkg; drives the frame store read port.
module sfc_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sfc_pkg::emit_req_t          req,
    output logic                        busy,
    output logic                        rd_en,
    output logic [sfc_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [sfc_pkg::BYTE_W-1:0]  rd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sfc_pkg::BYTE_W-1:0]  frame_byte,
    output logic [sfc_pkg::IDX_W-1:0]   byte_index,
    output logic                        last_byte
);
    import sfc_pkg::*;

    emit_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              pend_reg;
    logic [CNT_W-1:0]  pend_idx_reg;
    logic              pend_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic              issue, at_last;

    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        len_next    = len_reg;
        issue       = 1'b0;
        at_last     = (rd_idx_reg == len_reg - CNT_W'(1));
        unique case (state_reg)
            EM_IDLE: begin
                if (req.start) begin
                    state_next  = EM_READ;
                    rd_idx_next = '0;
                    len_next    = req.len;
                end
            end
            EM_READ: begin
                // one read in flight; issue once the output slot frees up
                if (!pend_reg && (!out_valid_reg || m_tready)) begin
                    issue       = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    if (at_last) begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default: state_next = EM_IDLE;
        endcase
        out_valid_next = out_valid_reg;
        if (pend_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= EM_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        len_reg    <= len_next;
        if (issue) begin
            pend_idx_reg  <= rd_idx_reg;
            pend_last_reg <= at_last;
        end
        if (pend_reg) begin
            out_byte_reg <= rd_data;
            out_idx_reg  <= IDX_W'(pend_idx_reg);
            out_last_reg <= pend_last_reg;
        end
    end

    assign busy       = (state_reg == EM_READ);
    assign rd_en      = issue;
    assign rd_addr    = rd_idx_reg[ADDR_W-1:0];
    assign m_tvalid   = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign last_byte  = out_last_reg;

endmodule

// ===== src/serial_frame_collector_top.sv =====
// Top level of the serial frame collector: collection, frame store and emission.
// Depends on sfc_pkg, sfc_collect, sfc_frame_ram and sfc_emit.
//
// Received bytes are taken one per cycle and written into a 32-byte frame store.
// Byte 0 carries the version, byte 1 the total length; a frame whose fill count
// reaches that length, ends in CR LF and starts with the configured version is
// sent out byte by byte with its index and a tlast on the final byte, and the
// store is emptied. A store holding more than 8 bytes that reaches the length or
// its capacity without a match is dropped. Input is accepted every cycle while
// collecting; once a frame completes, s_tready stays low from the next cycle until
// the read of its last byte is issued, which takes longer under output stalls.
// Emission keeps a single read of the store outstanding, with registered data, so
// it does not issue the next byte's read until the last one's data has landed.
// The store needs no clearing pass after reset. expected_version resets to 1.
module serial_frame_collector_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] frame_byte, [12:8] byte_index, [15:13] zero
    output logic        m_tlast,     // last_byte
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data  // expected_version
);
    import sfc_pkg::*;

    ram_wr_t           wr;
    emit_req_t         req;
    logic              busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;

    assign s_tready = !busy;

    sfc_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .wr          (wr),
        .req         (req)
    );

    sfc_frame_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfc_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .busy       (busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last_byte  (m_tlast)
    );

    assign m_tdata = {3'b000, byte_index, frame_byte};

endmodule

// ===== src/sfc_checker.sv =====
// Port-level checker for the serial frame collector, bound to the top level.
// Depends on serial_frame_collector_top_macros.svh.
`include "serial_frame_collector_top_macros.svh"

module sfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result item holds its contents
    `SFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // input stays closed while a frame still has bytes to come
    `SFC_ASSERT_SAME(a_in_closed, m_tvalid && !m_tlast, !s_tready)

    // every accepted frame ends in LF
    `SFC_ASSERT_SAME(a_last_lf, m_tvalid && m_tlast, m_tdata[7:0] == 8'h0A)

    // padding bits stay zero
    `SFC_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[15:13] == 3'b000)

endmodule

bind serial_frame_collector_top sfc_checker u_sfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for serial_frame_collector_top: drives received bytes and
// version writes, predicts emitted frames and compares every output item.
// Depends on sfc_pkg and the serial_frame_collector_top RTL.
module tb_top;
    import sfc_pkg::*;

    localparam int DRAIN_CYCLES   = 2 * FRAME_BYTES + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 42;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] idx;
        logic       last;
    } frame_out_t;

    // Frame predictor and the queue of frame bytes still owed by the block.
    class frame_scoreboard;
        bit [7:0]   held_bytes[FRAME_BYTES];
        int         held;
        bit [7:0]   version;
        frame_out_t owed_q[$];
        int         errors;
        int         bytes_in;
        int         bytes_out;
        int         frames_out;
        int         drops;

        function void empty_store();
            foreach (held_bytes[i]) held_bytes[i] = '0;
            held = 0;
        endfunction

        function void reset_state();
            empty_store();
            version = VERSION_RST;
        endfunction

        function int frame_len();
            return (held >= 2) ? int'(held_bytes[1]) : 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_input(bit [7:0] b);
            int         len;
            bit         ok;
            frame_out_t fo;
            bytes_in++;
            if (held < FRAME_BYTES) begin
                held_bytes[held] = b;
                held++;
            end else begin
                held_bytes[0] = b;
            end
            len = frame_len();
            ok  = (len == held) && (len >= 2) && (len <= FRAME_BYTES);
            if (ok)
                ok = (held_bytes[len-2] == CR_BYTE) && (held_bytes[len-1] == LF_BYTE) &&
                     (held_bytes[0] == version);
            if (ok) begin
                for (int i = 0; i < len; i++) begin
                    fo.data = held_bytes[i];
                    fo.idx  = i[4:0];
                    fo.last = (i + 1 == len);
                    owed_q.push_back(fo);
                end
                frames_out++;
                empty_store();
            end
            // drop a store of more than MIN_HELD bytes that has reached its length or capacity
            if (held > MIN_HELD && (held >= frame_len() || held == FRAME_BYTES)) begin
                drops++;
                empty_store();
            end
        endfunction

        function void check_result(logic [7:0] data, logic [4:0] idx, logic last);
            frame_out_t fo;
            bytes_out++;
            if (owed_q.size() == 0) begin
                $error("unexpected frame byte %0h at index %0d", data, idx);
                errors++;
                return;
            end
            fo = owed_q.pop_front();
            if (data !== fo.data) begin
                $error("frame_byte: expected %0h, got %0h", fo.data, data);
                errors++;
            end
            if (idx !== fo.idx) begin
                $error("byte_index: expected %0d, got %0d", fo.idx, idx);
                errors++;
            end
            if (last !== fo.last) begin
                $error("last_byte: expected %0b, got %0b", fo.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    frame_scoreboard sb;
    bit feed_gaps;
    bit drain_stalls;
    int quiet_cycles;

    serial_frame_collector_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Called at a falling edge; returns at a falling edge with s_tvalid still high.
    task automatic push_byte(input bit [7:0] b);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b);
        @(negedge aclk);
    endtask

    task automatic push_frame(input int n_bytes, input bit [7:0] ver,
                              input bit [7:0] len_byte, input bit tail_ok);
        bit [7:0] b;
        for (int i = 0; i < n_bytes; i++) begin
            b = 8'($urandom);
            if (i == 0)
                b = ver;
            else if (i == 1)
                b = len_byte;
            else if (tail_ok && i == n_bytes - 2)
                b = CR_BYTE;
            else if (tail_ok && i == n_bytes - 1)
                b = LF_BYTE;
            push_byte(b);
        end
    endtask

    // Write the version only once every owed frame byte is out and the block has settled.
    task automatic write_version(input bit [7:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.version = v;
    endtask

    task automatic run_random(input int target);
        int       start;
        int       pick;
        int       n;
        bit [7:0] lb;
        start = sb.bytes_in;
        while (sb.bytes_in - start < target) begin
            pick = $urandom_range(0, 99);
            n    = ($urandom_range(0, 99) < 85) ? $urandom_range(4, 12) : $urandom_range(13, 32);
            if (sb.held != 0 || pick >= 94) begin
                // flush leftovers with noise, or send stray noise into an empty store
                push_byte(8'($urandom));
            end else if (pick < 70) begin
                push_frame(n, sb.version, 8'(n), 1'b1);
            end else if (pick < 80) begin
                push_frame(n, sb.version ^ 8'($urandom_range(1, 255)), 8'(n), 1'b1);
            end else if (pick < 88) begin
                push_frame(n, sb.version, 8'(n), 1'b0);
            end else begin
                case ($urandom_range(0, 2))
                    0:       lb = 8'd0;
                    1:       lb = 8'd1;
                    default: lb = 8'($urandom_range(FRAME_BYTES + 1, 255));
                endcase
                push_frame(n, sb.version, lb, 1'b1);
            end
        end
    endtask

    // Output side: random stall before each item, sometimes none at all.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = drain_stalls ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[7:0], m_tdata[12:8], m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit [7:0] versions[5];
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        quiet_cycles = 0;
        feed_gaps    = 1'b1;
        drain_stalls = 1'b1;
        sb.reset_state();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: shortest frame, zero and all-ones bytes, wrong version, length below 2
        push_frame(4, VERSION_RST, 8'd4, 1'b1);
        push_byte(VERSION_RST);
        push_byte(8'd6);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CR_BYTE);
        push_byte(LF_BYTE);
        push_frame(9, 8'h02, 8'd9, 1'b1);
        push_frame(9, VERSION_RST, 8'd1, 1'b1);

        versions[0] = 8'h00;
        versions[1] = 8'hFF;
        versions[2] = 8'($urandom);
        versions[3] = 8'($urandom);
        versions[4] = VERSION_RST;
        foreach (versions[p]) begin
            write_version(versions[p]);
            feed_gaps    = ($urandom_range(0, 3) != 0);
            drain_stalls = ($urandom_range(0, 3) != 0);
            push_frame(FRAME_BYTES, sb.version, 8'(FRAME_BYTES), 1'b1);
            run_random(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d bytes; %0d frames predicted, %0d frame bytes checked, %0d drops.",
                 sb.bytes_in, sb.frames_out, sb.bytes_out, sb.drops);
        $display("Versions used: reset value, 0x00, 0xFF and two random values.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sfc_pkg.sv
src/sfc_frame_ram.sv
src/sfc_collect.sv
src/sfc_emit.sv
src/serial_frame_collector_top.sv
src/sfc_checker.sv
tb/tb_top.sv
